// ===== rtl/core/mbgf_pkg.sv =====
// Shared types and constants for the masked binomial grid filter.
package mbgf_pkg;

  localparam int COL_BITS    = 6;
  localparam int ROW_BITS    = 6;
  localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
  localparam int SAMPLE_BITS = 32;
  localparam int VALUE_BITS  = 32;
  localparam int STORE_BITS  = VALUE_BITS + 4;
  localparam int PASS_BITS   = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_COL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_ROW = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PASSES   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_J   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_K   = 3'd4;

  typedef struct packed {
    logic [1:0]                    op;
    logic [COL_BITS-1:0]           col;
    logic [ROW_BITS-1:0]           row;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          blocked;
  } in_item_t;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] result_value;
  } out_item_t;

  typedef enum logic [1:0] {
    FN_ADD,
    FN_ADD_SHR4,
    FN_AVG
  } alu_fn_t;

  typedef struct packed {
    alu_fn_t fn;
    logic    use_self;
  } alu_ctl_t;

endpackage

// ===== rtl/core/masked_binomial_grid_filter.sv =====
// Top level: handshakes, configuration registers, grid sequencer and stores.
//
// The block keeps a 64 x 64 grid of 36-bit node values and mask bits in two
// memories. A write item is stored as it is taken; a read item's word is
// registered in the memory, then in the output register, before it is
// offered. A run item walks the grid node by node through one shared
// adder: each node takes a memory read, then an add and write, in each of
// the four passes, then the enabled j and k edge averages, each edge pair
// averaged and written to both ends. This repeats pass_count times before
// the done word is offered. No item is taken while a run is active or a
// result word waits on the output. The stores need no clearing after reset.
module masked_binomial_grid_filter (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  mbgf_pkg::in_item_t                        in_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output mbgf_pkg::out_item_t                       out_data,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [mbgf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [mbgf_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_P_RD,
    S_P_WR,
    S_W_RD,
    S_W_WR0,
    S_W_WR1
  } state_t;

  state_t state;

  logic [mbgf_pkg::COL_BITS-1:0]  last_col;
  logic [mbgf_pkg::ROW_BITS-1:0]  last_row;
  logic [mbgf_pkg::PASS_BITS-1:0] passes;
  logic                           wrap_j;
  logic                           wrap_k;

  logic [mbgf_pkg::PASS_BITS-1:0] iter;
  logic [1:0]                     pass;
  logic [mbgf_pkg::COL_BITS-1:0]  cj;
  logic [mbgf_pkg::ROW_BITS-1:0]  ck;
  logic                           axis;
  logic [mbgf_pkg::COL_BITS-1:0]  wc;
  logic                           read_inside;
  logic signed [mbgf_pkg::STORE_BITS-1:0] avg;

  logic [mbgf_pkg::COL_BITS-1:0] aj, jm, jp;
  logic [mbgf_pkg::ROW_BITS-1:0] ak, km, kp;
  logic [mbgf_pkg::ADDR_BITS-1:0] self_addr, nb_addr, m0_addr, m1_addr;
  logic [mbgf_pkg::ADDR_BITS-1:0] wa_addr, wb_addr;
  logic [mbgf_pkg::ADDR_BITS-1:0] n_raddr0, n_raddr1, n_waddr;
  logic                           n_we, m_we;
  logic signed [mbgf_pkg::STORE_BITS-1:0] n_wdata, n_rdata0, n_rdata1, alu_out;
  logic [0:0] m_rdata0, m_rdata1;
  logic edge_node;
  logic in_acc, in_inside, iter_last, wlim_hit;
  mbgf_pkg::alu_ctl_t alu_ctl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign in_acc    = in_valid && in_ready;
  assign in_inside = (in_data.col <= last_col) && (in_data.row <= last_row);
  assign iter_last = (iter == passes - 8'd1);
  assign wlim_hit  = axis ? (wc == last_col) : (wc == last_row);

  // Node and mask addresses for the current pass; descending passes count
  // the position from the far edge.
  always_comb begin
    aj = (pass == 2'd1) ? last_col - cj : cj;
    ak = (pass == 2'd3) ? last_row - ck : ck;
    jm = (aj == '0) ? '0 : aj - 6'd1;
    km = (ak == '0) ? '0 : ak - 6'd1;
    jp = aj + 6'd1;
    kp = ak + 6'd1;
    self_addr = {aj, ak};
    case (pass)
      2'd0: begin
        nb_addr = {jp, ak};  m0_addr = {aj, ak};  m1_addr = {aj, km};
        edge_node = (aj == last_col);
      end
      2'd1: begin
        nb_addr = {jm, ak};  m0_addr = {jm, ak};  m1_addr = {jm, km};
        edge_node = (aj == '0);
      end
      2'd2: begin
        nb_addr = {aj, kp};  m0_addr = {aj, ak};  m1_addr = {jm, ak};
        edge_node = (ak == last_row);
      end
      default: begin
        nb_addr = {aj, km};  m0_addr = {aj, km};  m1_addr = {jm, km};
        edge_node = (ak == '0);
      end
    endcase
    wa_addr = axis ? {wc, 6'd0}   : {6'd0, wc};
    wb_addr = axis ? {wc, last_row} : {last_col, wc};
  end

  always_comb begin
    n_raddr0 = self_addr;
    n_raddr1 = nb_addr;
    n_we     = 1'b0;
    n_waddr  = self_addr;
    n_wdata  = alu_out;
    m_we     = 1'b0;
    alu_ctl.fn       = (pass == 2'd3) ? mbgf_pkg::FN_ADD_SHR4 : mbgf_pkg::FN_ADD;
    alu_ctl.use_self = edge_node || (m_rdata0[0] && m_rdata1[0]);
    unique case (state)
      S_IDLE: begin
        n_raddr0 = {in_data.col, in_data.row};
        n_waddr  = {in_data.col, in_data.row};
        n_wdata  = {{(mbgf_pkg::STORE_BITS-mbgf_pkg::SAMPLE_BITS){in_data.sample[31]}},
                    in_data.sample};
        n_we     = in_acc && (in_data.op == mbgf_pkg::OP_WRITE) && in_inside;
        m_we     = n_we;
      end
      S_P_WR: n_we = 1'b1;
      S_W_RD, S_W_WR0, S_W_WR1: begin
        n_raddr0 = wa_addr;
        n_raddr1 = wb_addr;
        alu_ctl.fn       = mbgf_pkg::FN_AVG;
        alu_ctl.use_self = 1'b0;
        if (state == S_W_WR0) begin
          n_we    = 1'b1;
          n_waddr = wa_addr;
        end else if (state == S_W_WR1) begin
          n_we    = 1'b1;
          n_waddr = wb_addr;
          n_wdata = avg;
        end
      end
      default: ;
    endcase
  end

  mbgf_ram #(.WIDTH(mbgf_pkg::STORE_BITS), .ADDR_BITS(mbgf_pkg::ADDR_BITS)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr0(n_raddr0), .raddr1(n_raddr1), .rdata0(n_rdata0), .rdata1(n_rdata1)
  );

  mbgf_ram #(.WIDTH(1), .ADDR_BITS(mbgf_pkg::ADDR_BITS)) u_mask_ram (
    .clk(clk), .we(m_we), .waddr(n_waddr), .wdata(in_data.blocked),
    .raddr0(m0_addr), .raddr1(m1_addr), .rdata0(m_rdata0), .rdata1(m_rdata1)
  );

  mbgf_alu u_alu (.ctl(alu_ctl), .a(n_rdata0), .b(n_rdata1), .result(alu_out));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last_col  <= 6'd63;
      last_row  <= 6'd63;
      passes    <= 8'd1;
      wrap_j    <= 1'b0;
      wrap_k    <= 1'b0;
      iter      <= '0;
      pass      <= '0;
      cj        <= '0;
      ck        <= '0;
      axis      <= 1'b0;
      wc        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mbgf_pkg::CFG_LAST_COL: last_col <= cfg_data[5:0];
          mbgf_pkg::CFG_LAST_ROW: last_row <= cfg_data[5:0];
          mbgf_pkg::CFG_PASSES:   passes   <= cfg_data;
          mbgf_pkg::CFG_WRAP_J:   wrap_j   <= cfg_data[0];
          mbgf_pkg::CFG_WRAP_K:   wrap_k   <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && in_data.op == mbgf_pkg::OP_READ) begin
            read_inside <= in_inside;
            state       <= S_RDWAIT;
          end else if (in_acc && in_data.op == mbgf_pkg::OP_RUN) begin
            iter <= '0;
            pass <= '0;
            cj   <= '0;
            ck   <= '0;
            if (passes == '0) begin
              out_valid <= 1'b1;
              out_data  <= '{kind: mbgf_pkg::KIND_DONE, result_value: '0};
            end else begin
              state <= S_P_RD;
            end
          end
        end
        S_RDWAIT: begin
          out_valid <= 1'b1;
          out_data  <= '{kind: mbgf_pkg::KIND_READ,
                         result_value: read_inside ? n_rdata0[31:0] : '0};
          state     <= S_IDLE;
        end
        S_P_RD: state <= S_P_WR;
        S_P_WR: begin
          state <= S_P_RD;
          if (ck != last_row) begin
            ck <= ck + 6'd1;
          end else begin
            ck <= '0;
            if (cj != last_col) begin
              cj <= cj + 6'd1;
            end else begin
              cj <= '0;
              if (pass != 2'd3) begin
                pass <= pass + 2'd1;
              end else begin
                pass <= '0;
                wc   <= '0;
                if (wrap_j || wrap_k) begin
                  axis  <= !wrap_j;
                  state <= S_W_RD;
                end else if (iter_last) begin
                  out_valid <= 1'b1;
                  out_data  <= '{kind: mbgf_pkg::KIND_DONE, result_value: '0};
                  state     <= S_IDLE;
                end else begin
                  iter <= iter + 8'd1;
                end
              end
            end
          end
        end
        S_W_RD: state <= S_W_WR0;
        S_W_WR0: begin
          avg   <= alu_out;
          state <= S_W_WR1;
        end
        S_W_WR1: begin
          state <= S_W_RD;
          if (!wlim_hit) begin
            wc <= wc + 6'd1;
          end else if (!axis && wrap_k) begin
            axis <= 1'b1;
            wc   <= '0;
          end else if (iter_last) begin
            out_valid <= 1'b1;
            out_data  <= '{kind: mbgf_pkg::KIND_DONE, result_value: '0};
            state     <= S_IDLE;
          end else begin
            iter  <= iter + 8'd1;
            state <= S_P_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A read or a run always leaves the idle state or raises a result word.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_data.op == mbgf_pkg::OP_RUN || in_data.op == mbgf_pkg::OP_READ))
    |=> !in_ready) else $error("block ready right after a read or run");

  // Grid position counters stay inside the configured grid during a run.
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_RD) |-> (cj <= last_col && ck <= last_row))
    else $error("grid position beyond the configured size");

  // The last pass of an iteration always scales down by sixteen.
  a_last_pass_shift: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_WR && pass == 2'd3) |-> (alu_ctl.fn == mbgf_pkg::FN_ADD_SHR4))
    else $error("last pass without the shift by four");

  // A result word appears only after a read cycle or at the end of a run.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RDWAIT || $past(state) == S_P_WR ||
                          $past(state) == S_W_WR1 || $past(state) == S_IDLE))
    else $error("result word from an unexpected state");
`endif

endmodule

// ===== rtl/core/mbgf_ram.sv =====
// Generic memory with one write port and two registered read ports.
module mbgf_ram #(
  parameter int WIDTH     = 36,
  parameter int ADDR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr0,
  input  logic [ADDR_BITS-1:0] raddr1,
  output logic [WIDTH-1:0]     rdata0,
  output logic [WIDTH-1:0]     rdata1
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== rtl/core/mbgf_alu.sv =====
// Shared adder with doubling select, floor shift by four and edge average.
module mbgf_alu (
  input  mbgf_pkg::alu_ctl_t                      ctl,
  input  logic signed [mbgf_pkg::STORE_BITS-1:0]  a,
  input  logic signed [mbgf_pkg::STORE_BITS-1:0]  b,
  output logic signed [mbgf_pkg::STORE_BITS-1:0]  result
);

  logic signed [mbgf_pkg::STORE_BITS:0] sum;
  logic signed [mbgf_pkg::STORE_BITS:0] shr4;
  logic signed [mbgf_pkg::STORE_BITS:0] shr1;
  logic signed [mbgf_pkg::STORE_BITS-1:0] b_sel;

  always_comb begin
    b_sel  = ctl.use_self ? a : b;
    sum    = {a[mbgf_pkg::STORE_BITS-1], a} + {b_sel[mbgf_pkg::STORE_BITS-1], b_sel};
    shr4   = sum >>> 4;
    shr1   = sum >>> 1;
    case (ctl.fn)
      mbgf_pkg::FN_ADD:      result = sum[mbgf_pkg::STORE_BITS-1:0];
      mbgf_pkg::FN_ADD_SHR4: result = shr4[mbgf_pkg::STORE_BITS-1:0];
      mbgf_pkg::FN_AVG:      result = shr1[mbgf_pkg::STORE_BITS-1:0];
      default:               result = sum[mbgf_pkg::STORE_BITS-1:0];
    endcase
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the masked binomial grid filter: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 1050;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  mbgf_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  mbgf_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [mbgf_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [mbgf_pkg::CFG_DATA_BITS-1:0] cfg_data;

  masked_binomial_grid_filter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the grid and registers.
  longint grid_val[64][64];
  bit grid_mask[64][64];
  bit grid_seen[64][64];
  int lim_j, lim_k, iter_count;
  bit wrap_j, wrap_k;

  mbgf_pkg::out_item_t pending_words[$];
  int errors;
  int cycles;
  int made;
  bit quiet;

  typedef struct {
    bit is_cfg;
    logic [mbgf_pkg::CFG_IDX_BITS-1:0] idx;
    logic [mbgf_pkg::CFG_DATA_BITS-1:0] val;
    mbgf_pkg::in_item_t item;
    bit typed;
    mbgf_pkg::out_item_t want;
  } table_row_t;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mbgf_pkg::in_item_t mk(logic [1:0] op, int c, int r, logic [31:0] s,
                                            bit b);
    mbgf_pkg::in_item_t it;
    it.op = op;
    it.col = c[5:0];
    it.row = r[5:0];
    it.sample = s;
    it.blocked = b;
    return it;
  endfunction

  function automatic void smooth_grid();
    int km, jm;
    for (int it = 0; it < iter_count; it++) begin
      for (int j = 0; j <= lim_j; j++)
        for (int k = 0; k <= lim_k; k++) begin
          km = k ? k - 1 : 0;
          if (j == lim_j || (grid_mask[j][k] && grid_mask[j][km]))
            grid_val[j][k] += grid_val[j][k];
          else
            grid_val[j][k] += grid_val[j+1][k];
        end
      for (int j = lim_j; j >= 0; j--)
        for (int k = 0; k <= lim_k; k++) begin
          km = k ? k - 1 : 0;
          if (j == 0 || (grid_mask[j-1][k] && grid_mask[j-1][km]))
            grid_val[j][k] += grid_val[j][k];
          else
            grid_val[j][k] += grid_val[j-1][k];
        end
      for (int j = 0; j <= lim_j; j++)
        for (int k = 0; k <= lim_k; k++) begin
          jm = j ? j - 1 : 0;
          if (k == lim_k || (grid_mask[j][k] && grid_mask[jm][k]))
            grid_val[j][k] += grid_val[j][k];
          else
            grid_val[j][k] += grid_val[j][k+1];
        end
      for (int j = 0; j <= lim_j; j++)
        for (int k = lim_k; k >= 0; k--) begin
          jm = j ? j - 1 : 0;
          if (k == 0 || (grid_mask[j][k-1] && grid_mask[jm][k-1]))
            grid_val[j][k] += grid_val[j][k];
          else
            grid_val[j][k] += grid_val[j][k-1];
          grid_val[j][k] = grid_val[j][k] >>> 4;
        end
      if (wrap_j)
        for (int k = 0; k <= lim_k; k++) begin
          grid_val[0][k] = (grid_val[0][k] + grid_val[lim_j][k]) >>> 1;
          grid_val[lim_j][k] = grid_val[0][k];
        end
      if (wrap_k)
        for (int j = 0; j <= lim_j; j++) begin
          grid_val[j][0] = (grid_val[j][0] + grid_val[j][lim_k]) >>> 1;
          grid_val[j][lim_k] = grid_val[j][0];
        end
    end
  endfunction

  // Updates the shadow grid for one accepted word; returns whether it causes an output word, given in w.
  function automatic bit predict_word(mbgf_pkg::in_item_t it, output mbgf_pkg::out_item_t w);
    bit in_grid;
    in_grid = (it.col <= lim_j) && (it.row <= lim_k);
    w = '0;
    case (it.op)
      mbgf_pkg::OP_WRITE: begin
        if (in_grid) begin
          grid_val[it.col][it.row] = longint'(it.sample);
          grid_mask[it.col][it.row] = it.blocked;
          grid_seen[it.col][it.row] = 1'b1;
        end
        return 1'b0;
      end
      mbgf_pkg::OP_RUN: begin
        smooth_grid();
        w.kind = mbgf_pkg::KIND_DONE;
        return 1'b1;
      end
      mbgf_pkg::OP_READ: begin
        w.kind = mbgf_pkg::KIND_READ;
        w.result_value = in_grid ? 32'(grid_val[it.col][it.row]) : 32'd0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic drive_word(mbgf_pkg::in_item_t it);
    int gap;
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_predicted(mbgf_pkg::in_item_t it);
    mbgf_pkg::out_item_t w;
    drive_word(it);
    if (predict_word(it, w)) pending_words.push_back(w);
  endtask

  // A run and every read must only touch written nodes, so fill any gap first.
  task automatic fill_grid();
    for (int j = 0; j <= lim_j; j++)
      for (int k = 0; k <= lim_k; k++)
        if (!grid_seen[j][k]) begin
          send_predicted(mk(mbgf_pkg::OP_WRITE, j, k, $urandom, 1'($urandom_range(1))));
          made++;
        end
  endtask

  task automatic write_reg(logic [mbgf_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mbgf_pkg::CFG_DATA_BITS-1:0] val);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mbgf_pkg::CFG_LAST_COL: lim_j = val & 63;
      mbgf_pkg::CFG_LAST_ROW: lim_k = val & 63;
      mbgf_pkg::CFG_PASSES:   iter_count = val;
      mbgf_pkg::CFG_WRAP_J:   wrap_j = val[0];
      mbgf_pkg::CFG_WRAP_K:   wrap_k = val[0];
      default: ;
    endcase
  endtask

  // Output side: random backpressure, comparison against the oldest expected word.
  int stall;
  always @(posedge clk) begin
    mbgf_pkg::out_item_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, actual kind=%0d value=%h", $realtime,
                 out_data.kind, out_data.result_value);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (want.kind !== out_data.kind)
          begin
            $display("%0t: kind mismatch, expected %0d actual %0d", $realtime,
                     want.kind, out_data.kind);
            errors++;
          end
        if (want.result_value !== out_data.result_value) begin
          $display("%0t: value mismatch, expected %h actual %h", $realtime,
                   want.result_value, out_data.result_value);
          errors++;
        end
      end
    end
    if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      stall <= $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t r;
    mbgf_pkg::in_item_t it;
    mbgf_pkg::out_item_t dummy;
    int phase, n, roll, c, k;
    bit b;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    made = 0;
    stall = 0;
    quiet = 1'b0;
    lim_j = 63;
    lim_k = 63;
    iter_count = 1;
    wrap_j = 1'b0;
    wrap_k = 1'b0;
    foreach (grid_seen[j, kk]) begin
      grid_seen[j][kk] = 1'b0;
      grid_val[j][kk] = 0;
      grid_mask[j][kk] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: extremes at the corners, unused op, out-of-range access, zero and one pass, wrap.
    r = '{default: '0};
    r.item = mk(mbgf_pkg::OP_WRITE, 0, 0, 32'h7fffffff, 1); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 0, 0, 0, 0); r.typed = 1;
    r.want = '{mbgf_pkg::KIND_READ, 32'h7fffffff};
    rows.push_back(r); r.typed = 0;
    r.item = mk(mbgf_pkg::OP_WRITE, 63, 63, 32'h80000000, 0); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 63, 63, 0, 1); r.typed = 1;
    r.want = '{mbgf_pkg::KIND_READ, 32'h80000000};
    rows.push_back(r); r.typed = 0;
    r.item = mk(mbgf_pkg::OP_WRITE, 63, 0, 32'hffffffff, 1); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 63, 0, 0, 0); r.typed = 1;
    r.want = '{mbgf_pkg::KIND_READ, 32'hffffffff};
    rows.push_back(r); r.typed = 0;
    r.item = mk(OP_UNUSED, 5, 5, 32'h12345, 1); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 0, 0, 0, 0); r.typed = 1;
    r.want = '{mbgf_pkg::KIND_READ, 32'h7fffffff};
    rows.push_back(r); r.typed = 0;
    r.is_cfg = 1; r.idx = mbgf_pkg::CFG_LAST_COL; r.val = 2; rows.push_back(r);
    r.idx = mbgf_pkg::CFG_LAST_ROW; r.val = 1; rows.push_back(r);
    r.idx = mbgf_pkg::CFG_PASSES; r.val = 0; rows.push_back(r); r.is_cfg = 0;
    r.item = mk(mbgf_pkg::OP_WRITE, 3, 0, 32'h5555, 1); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 3, 0, 0, 0); r.typed = 1;
    r.want = '{mbgf_pkg::KIND_READ, 32'd0};
    rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 0, 2, 0, 0); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_RUN, 0, 0, 0, 0); r.want = '{mbgf_pkg::KIND_DONE, 32'd0};
    rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 0, 0, 0, 0); r.want = '{mbgf_pkg::KIND_READ, 32'h7fffffff};
    rows.push_back(r); r.typed = 0;
    r.is_cfg = 1; r.idx = mbgf_pkg::CFG_PASSES; r.val = 1; rows.push_back(r); r.is_cfg = 0;
    r.item = mk(mbgf_pkg::OP_RUN, 0, 0, 0, 0); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 1, 1, 0, 0); rows.push_back(r);
    r.is_cfg = 1; r.idx = mbgf_pkg::CFG_WRAP_J; r.val = 1; rows.push_back(r);
    r.idx = mbgf_pkg::CFG_WRAP_K; r.val = 1; rows.push_back(r); r.is_cfg = 0;
    r.item = mk(mbgf_pkg::OP_RUN, 0, 0, 0, 0); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 2, 1, 0, 0); rows.push_back(r);
    r.item = mk(mbgf_pkg::OP_READ, 0, 0, 0, 0); rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        if (rows[i].item.op == mbgf_pkg::OP_RUN) fill_grid();
        if (rows[i].typed) begin
          drive_word(rows[i].item);
          void'(predict_word(rows[i].item, dummy));
          pending_words.push_back(rows[i].want);
        end else begin
          send_predicted(rows[i].item);
        end
      end
    end

    // Random phases, each with its own register setting; grid fill writes count as items.
    made = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      if (phase == 1) begin
        write_reg(mbgf_pkg::CFG_LAST_COL, 3);
        write_reg(mbgf_pkg::CFG_LAST_ROW, 63);
        write_reg(mbgf_pkg::CFG_PASSES, 1);
        write_reg(mbgf_pkg::CFG_WRAP_J, 1);
        write_reg(mbgf_pkg::CFG_WRAP_K, 1);
      end else if (phase == 3) begin
        write_reg(mbgf_pkg::CFG_LAST_COL, 1);
        write_reg(mbgf_pkg::CFG_LAST_ROW, 1);
        write_reg(mbgf_pkg::CFG_PASSES, 255);
        write_reg(mbgf_pkg::CFG_WRAP_J, 8'($urandom_range(1)));
        write_reg(mbgf_pkg::CFG_WRAP_K, 1);
      end else begin
        if ($urandom_range(7) == 0) begin
          write_reg(mbgf_pkg::CFG_LAST_COL, $urandom_range(1) ? 8'd63 : 8'd0);
          write_reg(mbgf_pkg::CFG_LAST_ROW, 8'($urandom_range(3)));
          write_reg(mbgf_pkg::CFG_PASSES, 8'($urandom_range(2)));
        end else begin
          write_reg(mbgf_pkg::CFG_LAST_COL, 8'($urandom_range(7)));
          write_reg(mbgf_pkg::CFG_LAST_ROW, 8'($urandom_range(7)));
          write_reg(mbgf_pkg::CFG_PASSES, 8'($urandom_range(4)));
        end
        write_reg(mbgf_pkg::CFG_WRAP_J, 8'($urandom_range(1)));
        write_reg(mbgf_pkg::CFG_WRAP_K, 8'($urandom_range(1)));
      end
      if (made > RANDOM_ITEMS - 80) quiet = 1'b1;
      n = (phase == 1) ? 12 : 60;
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(99);
        if ($urandom_range(9) < 7) begin
          c = $urandom_range(lim_j);
          k = $urandom_range(lim_k);
        end else begin
          c = $urandom_range(63);
          k = $urandom_range(63);
        end
        b = 1'($urandom_range(1));
        case ($urandom_range(3))
          0: it = mk(mbgf_pkg::OP_WRITE, c, k, 32'h7fffffff, b);
          1: it = mk(mbgf_pkg::OP_WRITE, c, k, 32'h80000000, b);
          default: it = mk(mbgf_pkg::OP_WRITE, c, k, $urandom, b);
        endcase
        if (roll < 40) begin
          it.op = mbgf_pkg::OP_READ;
          // Never read a node in the grid that has not been written.
          if (c <= lim_j && k <= lim_k && !grid_seen[c][k]) it.op = mbgf_pkg::OP_WRITE;
        end else if (roll < 48) begin
          it.op = mbgf_pkg::OP_RUN;
          fill_grid();
        end else if (roll < 52) begin
          it.op = OP_UNUSED;
          made--;
        end
        send_predicted(it);
        made++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
